FILE: design/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_MAX_SCALAR  = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;

  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_LO   = 8'h80;
  localparam logic [7:0] CONT_HI   = 8'hBF;

  // Decoder state held between bytes.
  typedef struct packed {
    logic [1:0]      pending_count;
    logic [2:0]      expected_length;
    logic [CP_W-1:0] partial_value;
    logic [7:0]      next_low_bound;
    logic [7:0]      next_high_bound;
  } seq_state_t;

  // One decoded result.
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_of_run;
  } result_t;

  localparam seq_state_t SEQ_IDLE = '{
    pending_count:   2'd0,
    expected_length: 3'd0,
    partial_value:   '0,
    next_low_bound:  CONT_LO,
    next_high_bound: CONT_HI
  };

endpackage

FILE: design/utf8d_decode.sv
// Per-byte UTF-8 decode logic with the sequence state registers.
module utf8d_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          byte_value,
  output logic [1:0]          push_count,
  output utf8d_pkg::result_t  res0,
  output utf8d_pkg::result_t  res1
);

  typedef struct packed {
    logic                  emit;
    logic [20:0]           cp;
    utf8d_pkg::seq_state_t st;
  } fresh_t;

  // Handle a byte with no sequence open.
  function automatic fresh_t fresh_start(input logic [7:0] b);
    fresh_t f;
    f.emit = 1'b0;
    f.cp   = '0;
    f.st   = utf8d_pkg::SEQ_IDLE;
    if (b <= utf8d_pkg::ASCII_MAX) begin
      f.emit = 1'b1;
      f.cp   = {13'd0, b};
    end else if (b inside {[8'hC2:8'hDF]}) begin
      f.st.pending_count   = 2'd1;
      f.st.expected_length = 3'd2;
      f.st.partial_value   = {16'd0, b[4:0]};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      f.st.pending_count   = 2'd1;
      f.st.expected_length = 3'd3;
      f.st.partial_value   = {17'd0, b[3:0]};
      f.st.next_low_bound  = (b == 8'hE0) ? 8'hA0 : utf8d_pkg::CONT_LO;
      f.st.next_high_bound = (b == 8'hED) ? 8'h9F : utf8d_pkg::CONT_HI;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      f.st.pending_count   = 2'd1;
      f.st.expected_length = 3'd4;
      f.st.partial_value   = {18'd0, b[2:0]};
      f.st.next_low_bound  = (b == 8'hF0) ? 8'h90 : utf8d_pkg::CONT_LO;
      f.st.next_high_bound = (b == 8'hF4) ? 8'h8F : utf8d_pkg::CONT_HI;
    end else begin
      f.emit = 1'b1;
      f.cp   = utf8d_pkg::CP_REPLACEMENT;
    end
    return f;
  endfunction

  utf8d_pkg::seq_state_t seq;
  utf8d_pkg::seq_state_t seq_next;

  fresh_t            fr;
  logic              in_bounds;
  logic [1:0]        cnt_inc;
  logic [20:0]       acc;
  logic              complete;
  logic [20:0]       done_cp;

  always_comb begin
    fr        = fresh_start(byte_value);
    in_bounds = (byte_value >= seq.next_low_bound) && (byte_value <= seq.next_high_bound);
    cnt_inc   = seq.pending_count + 2'd1;
    acc       = {seq.partial_value[14:0], byte_value[5:0]};
    // the fourth byte wraps the count to zero
    complete  = (cnt_inc == 2'd0) || ({1'b0, cnt_inc} >= seq.expected_length);
    done_cp   = acc;
    if ((acc > utf8d_pkg::CP_MAX_SCALAR) ||
        ((acc >= utf8d_pkg::CP_SURR_LO) && (acc <= utf8d_pkg::CP_SURR_HI))) begin
      done_cp = utf8d_pkg::CP_REPLACEMENT;
    end

    seq_next   = seq;
    push_count = 2'd0;
    res0       = '{code_point: fr.cp, last_of_run: 1'b1};
    res1       = '{code_point: fr.cp, last_of_run: 1'b1};

    if (seq.pending_count == 2'd0) begin
      seq_next   = fr.st;
      push_count = {1'b0, fr.emit};
    end else if (in_bounds) begin
      if (complete) begin
        seq_next   = utf8d_pkg::SEQ_IDLE;
        push_count = 2'd1;
        res0       = '{code_point: done_cp, last_of_run: 1'b1};
      end else begin
        seq_next.pending_count   = cnt_inc;
        seq_next.partial_value   = acc;
        seq_next.next_low_bound  = utf8d_pkg::CONT_LO;
        seq_next.next_high_bound = utf8d_pkg::CONT_HI;
      end
    end else begin
      // drop the broken sequence, then restart on the same byte
      seq_next   = fr.st;
      push_count = fr.emit ? 2'd2 : 2'd1;
      res0       = '{code_point: utf8d_pkg::CP_REPLACEMENT, last_of_run: ~fr.emit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= utf8d_pkg::SEQ_IDLE;
    end else if (advance) begin
      seq <= seq_next;
    end
  end

endmodule

FILE: design/utf8d_outq.sv
// Four-entry result queue that takes up to two results per cycle.
module utf8d_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  utf8d_pkg::result_t  res0,
  input  utf8d_pkg::result_t  res1,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [20:0]         code_point,
  output logic                last_of_run
);

  utf8d_pkg::result_t entry [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       pop;
  logic [1:0] wr_ptr1;

  assign out_valid   = (count != 3'd0);
  assign code_point  = entry[rd_ptr].code_point;
  assign last_of_run = entry[rd_ptr].last_of_run;
  assign pop         = out_valid && !out_stall;
  // room for two more results, judged on the registered count
  assign room        = (count <= 3'd2);
  assign wr_ptr1     = wr_ptr + 2'd1;
  assign count_next  = count + {1'b0, push_count} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entry[wr_ptr] <= res0;
    end
    if (push_count == 2'd2) begin
      entry[wr_ptr1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

endmodule

FILE: design/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decoder and result queue.
//
// Decodes a UTF-8 byte stream into Unicode code points, one byte per beat on
// the input channel. Bytes 00..7F with no sequence open pass straight through;
// a valid multibyte sequence yields its code point on the beat of its last
// byte, and bytes that only open or extend a sequence yield nothing. Validity
// is strict UTF-8 (overlongs, surrogates and values above 10FFFF are refused
// byte by byte). Each refused maximal subpart yields one U+FFFD; a byte that
// breaks an open sequence is then decoded again as a fresh start, so one
// input beat can give two output beats. last_of_run marks the final result
// of an input byte. Flow: a byte is registered on acceptance, decoded
// combinationally from the input register and written into a four-entry
// result queue, whose registered entries are offered on the output. A new
// byte is taken every cycle as long as the queue holds at most two results;
// the one-result-per-cycle output port, when the receiver does not stall,
// sets the sustained rate when bytes give two results. Both channels use
// valid/stall; in_stall rises when the input register holds a byte that the
// queue has no room for.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic        last_of_run
);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;

  logic               room;
  logic               advance;
  logic [1:0]         push_raw;
  logic [1:0]         push_count;
  utf8d_pkg::result_t res0;
  utf8d_pkg::result_t res1;

  // Advance the held byte into the decoder when the queue can take its results.
  assign advance    = s1_valid && room;
  assign in_stall   = s1_valid && !room;
  assign push_count = advance ? push_raw : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the byte while stalled; load a new one on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= byte_value;
    end
  end

  utf8d_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .byte_value (s1_byte),
    .push_count (push_raw),
    .res0       (res0),
    .res1       (res1)
  );

  utf8d_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .res0        (res0),
    .res1        (res1),
    .room        (room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .last_of_run (last_of_run)
  );

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the UTF-8 stream decoder.
module tb;

  typedef logic [utf8d_pkg::CP_W-1:0] cp_t;

  // Lead byte ranges and the narrowed second-byte bounds of strict UTF-8.
  localparam logic [7:0] LEAD2_MIN    = 8'hC2;
  localparam logic [7:0] LEAD2_MAX    = 8'hDF;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD3_SURR   = 8'hED;
  localparam logic [7:0] LEAD3_MAX    = 8'hEF;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD4_MAX    = 8'hF4;
  localparam logic [7:0] E0_SECOND_LO = 8'hA0;
  localparam logic [7:0] ED_SECOND_HI = 8'h9F;
  localparam logic [7:0] F0_SECOND_LO = 8'h90;
  localparam logic [7:0] F4_SECOND_HI = 8'h8F;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_PRINTED  = 20;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        byte_value = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  cp_t               code_point;
  logic              last_of_run;

  utf8_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .byte_value  (byte_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .last_of_run (last_of_run)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Decoder state as the testbench sees it, and the code points still owed.
  utf8d_pkg::seq_state_t seq_st = utf8d_pkg::SEQ_IDLE;
  utf8d_pkg::result_t    expected_cps[$];
  logic [7:0]            seq_bytes[$];
  int                    errors = 0;
  int                    cycle_count = 0;
  bit                    no_gaps = 1'b0;   // set for stretches with no idling on either side
  int                    hold_left = 0;    // receiver hold-off requested by a test
  int                    stall_left = 0;

  // Pick an idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Handle a byte with no sequence open; return 1 and the code point when
  // the byte yields a result, 0 when it opens a sequence.
  function automatic bit start_fresh(input logic [7:0] b, output cp_t cp);
    cp = utf8d_pkg::CP_REPLACEMENT;
    if (b <= utf8d_pkg::ASCII_MAX) begin
      cp = {13'd0, b};
      return 1'b1;
    end
    if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      seq_st = '{pending_count: 2'd1, expected_length: 3'd2,
                 partial_value: {16'd0, b[4:0]},
                 next_low_bound: utf8d_pkg::CONT_LO,
                 next_high_bound: utf8d_pkg::CONT_HI};
      return 1'b0;
    end
    if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      seq_st = '{pending_count: 2'd1, expected_length: 3'd3,
                 partial_value: {17'd0, b[3:0]},
                 next_low_bound: (b == LEAD3_MIN) ? E0_SECOND_LO : utf8d_pkg::CONT_LO,
                 next_high_bound: (b == LEAD3_SURR) ? ED_SECOND_HI : utf8d_pkg::CONT_HI};
      return 1'b0;
    end
    if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      seq_st = '{pending_count: 2'd1, expected_length: 3'd4,
                 partial_value: {18'd0, b[2:0]},
                 next_low_bound: (b == LEAD4_MIN) ? F0_SECOND_LO : utf8d_pkg::CONT_LO,
                 next_high_bound: (b == LEAD4_MAX) ? F4_SECOND_HI : utf8d_pkg::CONT_HI};
      return 1'b0;
    end
    // Stray continuation, overlong lead or byte beyond F4.
    return 1'b1;
  endfunction

  // Advance the decoder state by one accepted byte and queue its results.
  function automatic void decode_byte(input logic [7:0] b);
    cp_t                cps[$];
    cp_t                cp;
    utf8d_pkg::result_t r;
    if (seq_st.pending_count == 2'd0) begin
      if (start_fresh(b, cp)) cps = {cps, cp};
    end else if (b >= seq_st.next_low_bound && b <= seq_st.next_high_bound) begin
      seq_st.partial_value   = {seq_st.partial_value[utf8d_pkg::CP_W-7:0], b[5:0]};
      seq_st.pending_count   = seq_st.pending_count + 2'd1;
      seq_st.next_low_bound  = utf8d_pkg::CONT_LO;
      seq_st.next_high_bound = utf8d_pkg::CONT_HI;
      // A four-byte sequence wraps the two-bit count back to zero.
      if (seq_st.pending_count == 2'd0 ||
          {1'b0, seq_st.pending_count} >= seq_st.expected_length) begin
        cp = seq_st.partial_value;
        if (cp > utf8d_pkg::CP_MAX_SCALAR ||
            (cp >= utf8d_pkg::CP_SURR_LO && cp <= utf8d_pkg::CP_SURR_HI))
          cp = utf8d_pkg::CP_REPLACEMENT;
        seq_st = utf8d_pkg::SEQ_IDLE;
        cps = {cps, cp};
      end
    end else begin
      // Broken sequence: replace it, then take the byte again as a fresh start.
      seq_st = utf8d_pkg::SEQ_IDLE;
      cps = {cps, utf8d_pkg::CP_REPLACEMENT};
      if (start_fresh(b, cp)) cps = {cps, cp};
    end
    foreach (cps[i]) begin
      r.code_point  = cps[i];
      r.last_of_run = (i == cps.size() - 1);
      expected_cps = {expected_cps, r};
    end
  endfunction

  // Build the UTF-8 bytes of one scalar value.
  function automatic void encode_scalar(input cp_t cp);
    seq_bytes.delete();
    if (cp < 21'h80) begin
      seq_bytes = {seq_bytes, cp[7:0]};
    end else if (cp < 21'h800) begin
      seq_bytes = {seq_bytes, {3'b110, cp[10:6]}};
      seq_bytes = {seq_bytes, {2'b10, cp[5:0]}};
    end else if (cp < 21'h10000) begin
      seq_bytes = {seq_bytes, {4'b1110, cp[15:12]}};
      seq_bytes = {seq_bytes, {2'b10, cp[11:6]}};
      seq_bytes = {seq_bytes, {2'b10, cp[5:0]}};
    end else begin
      seq_bytes = {seq_bytes, {5'b11110, cp[20:18]}};
      seq_bytes = {seq_bytes, {2'b10, cp[17:12]}};
      seq_bytes = {seq_bytes, {2'b10, cp[11:6]}};
      seq_bytes = {seq_bytes, {2'b10, cp[5:0]}};
    end
  endfunction

  // Random scalar value of a random length, edges now and then.
  function automatic cp_t rand_scalar();
    cp_t edges[10] = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                       21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};
    cp_t cp;
    if ($urandom_range(0, 9) == 0) return edges[$urandom_range(0, 9)];
    case ($urandom_range(0, 3))
      0: cp = cp_t'($urandom_range(0, 'h7F));
      1: cp = cp_t'($urandom_range('h80, 'h7FF));
      2: begin
        cp = cp_t'($urandom_range('h800, 'hFFFF));
        while (cp >= utf8d_pkg::CP_SURR_LO && cp <= utf8d_pkg::CP_SURR_HI)
          cp = cp_t'($urandom_range('h800, 'hFFFF));
      end
      default: cp = cp_t'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // Offer one byte after a random idle stretch and hold it until accepted.
  // Valid stays high between back-to-back beats; only an idle stretch drops it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid   = 1'b0;
      byte_value = 8'($urandom_range(0, 255));
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   = 1'b1;
    byte_value = b;
    do @(posedge clk); while (in_stall);
    decode_byte(b);
  endtask

  task automatic send_bytes(input logic [7:0] bs[$]);
    foreach (bs[i]) send_byte(bs[i]);
  endtask

  // Drop valid and wait for every owed result to come out.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input cp_t got, input cp_t want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  // Receiver: a requested hold-off wins, then calm stretches, then random stalls.
  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (no_gaps) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall  = (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Compare each accepted result beat with the oldest owed code point.
  always @(posedge clk) begin
    utf8d_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cps.size() == 0) begin
        report_mismatch("unexpected result, code_point", code_point, '0);
      end else begin
        want = expected_cps.pop_front();
        if (code_point !== want.code_point)
          report_mismatch("code_point", code_point, want.code_point);
        if (last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", {20'd0, last_of_run}, {20'd0, want.last_of_run});
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // ASCII extremes and every kind of refused lead byte.
  task automatic test_ascii_and_bad_leads();
    send_bytes('{8'h00, 8'h7F, 8'h80, 8'hC1, 8'hF5, 8'hFF});
  endtask

  // Well-formed sequences of two, three and four bytes at the bound edges.
  task automatic test_valid_sequences();
    send_bytes('{8'hC2, 8'h80});
    send_bytes('{8'hE0, 8'hA0, 8'h80});
    send_bytes('{8'hF4, 8'h8F, 8'hBF, 8'hBF});
  endtask

  // Sequences broken by an out-of-bounds byte: the surrogate and overlong
  // second bytes, an ASCII byte, and a new lead that opens the next sequence.
  task automatic test_broken_sequences();
    send_bytes('{8'hED, 8'hA0});
    send_bytes('{8'hF0, 8'h8F});
    send_bytes('{8'hC2, 8'h41});
    send_bytes('{8'hE1, 8'h80, 8'hC3, 8'hA9});
  endtask

  // Mostly well-formed text with random content; the rest is truncated
  // sequences and raw noise bytes. Toggle calm stretches now and then.
  task automatic test_random_stream(input int n_bytes);
    int sent;
    int kind;
    int keep;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        encode_scalar(rand_scalar());
      end else if (kind < 85) begin
        // Cut a multibyte sequence short and follow it with any byte.
        encode_scalar(cp_t'($urandom_range('h80, 'h10FFFF)));
        if (seq_bytes.size() < 2) encode_scalar(21'h10000);
        keep = $urandom_range(1, seq_bytes.size() - 1);
        while (seq_bytes.size() > keep) void'(seq_bytes.pop_back());
        seq_bytes = {seq_bytes, 8'($urandom_range(0, 255))};
      end else begin
        seq_bytes.delete();
        seq_bytes = {seq_bytes, 8'($urandom_range(0, 255))};
      end
      send_bytes(seq_bytes);
      sent += seq_bytes.size();
    end
    no_gaps = 1'b0;
  endtask

  // Hold the output off for a long stretch while bytes keep coming, so the
  // result queue fills and the input stalls.
  task automatic test_output_hold();
    no_gaps   = 1'b1;
    hold_left = 300;
    repeat (25) begin
      encode_scalar(rand_scalar());
      send_bytes(seq_bytes);
      // Two-result bytes fill the queue fastest.
      send_bytes('{8'hC2, 8'h41});
    end
    no_gaps = 1'b0;
  endtask

  // Pause the sender until every owed result is out, then resume.
  task automatic test_sender_pause();
    repeat (10) begin
      encode_scalar(rand_scalar());
      send_bytes(seq_bytes);
    end
    wait_results_drained();
    test_random_stream(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ascii_and_bad_leads();
    test_valid_sequences();
    test_broken_sequences();
    test_random_stream(1200);
    test_output_hold();
    test_sender_pause();
    test_random_stream(150);

    // Let the pipeline settle so any stray extra beat is caught.
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
